// ----- hw/rtl/elsc_pkg.sv -----
// ----------------------------------------------------------------------------
// elsc_pkg
// Shared types and constants of the ELF load segment checker.
// ----------------------------------------------------------------------------
`default_nettype none

package elsc_pkg;

  localparam int unsigned MAX_HEADERS = 8;
  localparam int unsigned TABLE_DEPTH = 8;
  localparam int unsigned HC_W        = $clog2(MAX_HEADERS + 1);
  localparam int unsigned SC_W        = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);

  localparam logic [31:0] MIN_ALIGN = 32'h0000_1000;
  localparam logic [31:0] HIGH_HALF = 32'h8000_0000;
  localparam logic [31:0] LOAD_TYPE = 32'h0000_0001;

  localparam int unsigned PADDR_W = 5;

  localparam logic [2:0] REG_IMAGE_BYTES   = 3'd0;
  localparam logic [2:0] REG_ENTRY_POINT   = 3'd1;
  localparam logic [2:0] REG_RAM_SIZE      = 3'd2;
  localparam logic [2:0] REG_LOW_WIN_START = 3'd3;
  localparam logic [2:0] REG_LOW_WIN_END   = 3'd4;
  localparam logic [2:0] REG_HIGH_WIN_START = 3'd5;

  typedef enum logic [3:0] {
    ST_LOADED   = 4'd0,
    ST_SKIPPED  = 4'd1,
    ST_SIZE     = 4'd2,
    ST_REGION   = 4'd3,
    ST_ALIGN    = 4'd4,
    ST_MAPPING  = 4'd5,
    ST_OVERLAP  = 4'd6,
    ST_TOO_MANY = 4'd7,
    ST_EARLIER  = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SIZE,
    S_REGION,
    S_ALIGN,
    S_MAP,
    S_WALK,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/elsc_if.sv -----
// ----------------------------------------------------------------------------
// elsc_if
// Valid/ready channels for program header requests and check results.
// ----------------------------------------------------------------------------
`default_nettype none

interface elsc_hdr_if;
  logic        valid;
  logic        ready;
  logic [31:0] segment_type;
  logic [31:0] file_offset;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr;
  logic [31:0] file_size;
  logic [31:0] mem_size;
  logic        exec_flag;
  logic [31:0] align_bytes;
  logic        is_last;

  modport source (
    output valid, segment_type, file_offset, virt_addr, phys_addr, file_size,
           mem_size, exec_flag, align_bytes, is_last,
    input  ready
  );
  modport sink (
    input  valid, segment_type, file_offset, virt_addr, phys_addr, file_size,
           mem_size, exec_flag, align_bytes, is_last,
    output ready
  );
endinterface

interface elsc_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] fill_start;
  logic [31:0] fill_length;
  logic [31:0] image_end;
  logic        entry_found;
  logic        run_done;
  logic [31:0] final_entry;

  modport source (
    output valid, status, fill_start, fill_length, image_end, entry_found,
           run_done, final_entry,
    input  ready
  );
  modport sink (
    input  valid, status, fill_start, fill_length, image_end, entry_found,
           run_done, final_entry,
    output ready
  );
endinterface

`default_nettype wire

// ----- hw/rtl/elf_load_segment_checker_core.sv -----
// ----------------------------------------------------------------------------
// elf_load_segment_checker_core
// Validates ELF32 program headers of a kernel image one request at a time.
//
// Requests arrive on hdr, one program header each; every request yields one
// result on res. Six 32-bit registers on the APB port (image size, entry
// point, RAM size, window bounds) are to be written by the user while the
// block is idle; the block itself does not enforce this. A request walks a
// small sequencer: start, size, region, alignment and mapping checks, then
// an overlap walk over the stored segments, one per cycle, then a finish
// state that loads the output register. The walk covers the segments stored
// so far (0 to 8); headers skipped or failed before it bypass it. hdr.ready
// is high only in the idle state, entered in the cycle after the finish
// state loads the output register, so a new request is taken only once the
// previous one is through the sequencer, and it may be taken while the
// previous result still waits in the output register. When the receiver
// stalls, a finished request holds in the finish state until the output
// register frees.
// Reset clears the registers, the run state and the output valid flag.
// The header marked last closes the run and clears the run state.
// ----------------------------------------------------------------------------
`default_nettype none

module elf_load_segment_checker_core
  import elsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready,
  elsc_hdr_if.sink                hdr,
  elsc_res_if.source              res
);

  logic [31:0] image_bytes, entry_point, ram_size;
  logic [31:0] low_window_start, low_window_end, high_window_start;

  logic [31:0] seg_start_table [TABLE_DEPTH];
  logic [31:0] seg_end_table   [TABLE_DEPTH];
  logic [SC_W-1:0] stored_count;
  logic [HC_W-1:0] header_count;
  logic [31:0] highest_end;
  logic        entry_seen;
  logic        failed_flag;

  state_t state, state_next;

  logic [31:0] seg_type, off, virt, phys, fsz, msz, algn;
  logic        exec, last;
  logic [31:0] phys_end;
  logic        entry_hit;
  status_t     status;
  logic [IDX_W-1:0] walk_idx;

  logic        out_valid;
  logic [3:0]  out_status;
  logic [31:0] out_fill_start, out_fill_length, out_image_end, out_final_entry;
  logic        out_entry_found, out_run_done;

  logic        cfg_write;
  logic [2:0]  cfg_idx;
  logic        accept;
  logic        finish_load;

  logic        size_fail, region_fail, align_fail, map_fail;
  logic [32:0] image_rem, region_sum;
  logic [31:0] algn_mask;
  logic        walk_hit, walk_last, table_full;
  logic        loaded;

  logic            failed_new, seen_new;
  logic [SC_W-1:0] count_new;
  logic [31:0]     high_new;

  // APB register file.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[4:2];

  always_comb begin
    unique case (cfg_idx)
      REG_IMAGE_BYTES:    prdata = image_bytes;
      REG_ENTRY_POINT:    prdata = entry_point;
      REG_RAM_SIZE:       prdata = ram_size;
      REG_LOW_WIN_START:  prdata = low_window_start;
      REG_LOW_WIN_END:    prdata = low_window_end;
      REG_HIGH_WIN_START: prdata = high_window_start;
      default:            prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_bytes       <= 32'h0;
      entry_point       <= 32'h0;
      ram_size          <= 32'h0;
      low_window_start  <= 32'h0;
      low_window_end    <= 32'h0;
      high_window_start <= 32'h0;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_IMAGE_BYTES:    image_bytes       <= pwdata;
        REG_ENTRY_POINT:    entry_point       <= pwdata;
        REG_RAM_SIZE:       ram_size          <= pwdata;
        REG_LOW_WIN_START:  low_window_start  <= pwdata;
        REG_LOW_WIN_END:    low_window_end    <= pwdata;
        REG_HIGH_WIN_START: high_window_start <= pwdata;
        default: ;
      endcase
    end
  end

  // Check conditions, one group per sequencer step.
  assign image_rem  = {1'b0, image_bytes} - {1'b0, off};
  assign size_fail  = (fsz > msz) || (off > image_bytes) ||
                      ({1'b0, fsz} > image_rem);
  assign region_sum = {1'b0, phys} + {1'b0, msz};
  assign region_fail = (msz == 32'h0) || region_sum[32] ||
                       !(((phys >= low_window_start) &&
                          (region_sum[31:0] <= low_window_end)) ||
                         ((phys >= high_window_start) &&
                          (region_sum[31:0] <= ram_size)));
  assign algn_mask  = algn - 32'h1;
  assign align_fail = (algn < MIN_ALIGN) || ((algn & algn_mask) != 32'h0) ||
                      (((off ^ virt) & algn_mask) != 32'h0);
  assign map_fail   = virt[31] ? ((virt - phys) != HIGH_HALF) : (virt != phys);
  assign walk_hit   = (phys < seg_end_table[walk_idx]) &&
                      (seg_start_table[walk_idx] < phys_end);
  assign walk_last  = (SC_W'(walk_idx) + SC_W'(1)) == stored_count;
  assign table_full = stored_count >= SC_W'(TABLE_DEPTH);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (hdr.valid) state_next = S_START;
      S_START: begin
        priority if (failed_flag || header_count >= HC_W'(MAX_HEADERS) ||
                     seg_type != LOAD_TYPE) state_next = S_FINISH;
        else state_next = S_SIZE;
      end
      S_SIZE:   state_next = size_fail ? S_FINISH : S_REGION;
      S_REGION: state_next = region_fail ? S_FINISH : S_ALIGN;
      S_ALIGN:  state_next = align_fail ? S_FINISH : S_MAP;
      S_MAP: begin
        priority if (map_fail || stored_count == SC_W'(0)) state_next = S_FINISH;
        else state_next = S_WALK;
      end
      S_WALK:   if (walk_hit || walk_last) state_next = S_FINISH;
      S_FINISH: if (finish_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    hdr.ready   = (state == S_IDLE);
    accept      = hdr.valid && (state == S_IDLE);
    finish_load = (state == S_FINISH) && (!out_valid || res.ready);
  end

  // Run state after this request, before the close of the run.
  assign loaded     = (status == ST_LOADED);
  assign failed_new = failed_flag || ((status != ST_LOADED) &&
                      (status != ST_SKIPPED) && (status != ST_EARLIER));
  assign count_new  = loaded ? stored_count + SC_W'(1) : stored_count;
  assign seen_new   = entry_seen || (loaded && exec && entry_hit);
  assign high_new   = (loaded && (phys_end > highest_end)) ? phys_end : highest_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      seg_type <= hdr.segment_type;
      off      <= hdr.file_offset;
      virt     <= hdr.virt_addr;
      phys     <= hdr.phys_addr;
      fsz      <= hdr.file_size;
      msz      <= hdr.mem_size;
      exec     <= hdr.exec_flag;
      algn     <= hdr.align_bytes;
      last     <= hdr.is_last;
      status   <= ST_LOADED;
    end
    unique case (state)
      S_START: begin
        if (failed_flag) status <= ST_EARLIER;
        else if (header_count >= HC_W'(MAX_HEADERS)) status <= ST_TOO_MANY;
        else if (seg_type != LOAD_TYPE) status <= ST_SKIPPED;
      end
      S_SIZE:   if (size_fail) status <= ST_SIZE;
      S_REGION: begin
        phys_end <= region_sum[31:0];
        if (region_fail) status <= ST_REGION;
      end
      S_ALIGN:  if (align_fail) status <= ST_ALIGN;
      S_MAP: begin
        entry_hit <= (entry_point >= phys) && (entry_point < phys_end);
        walk_idx  <= '0;
        if (map_fail) status <= ST_MAPPING;
      end
      S_WALK: begin
        walk_idx <= walk_idx + IDX_W'(1);
        if (walk_hit) status <= ST_OVERLAP;
        else if (walk_last && table_full) status <= ST_TOO_MANY;
      end
      default: ;
    endcase
    if (finish_load && loaded) begin
      seg_start_table[stored_count[IDX_W-1:0]] <= phys;
      seg_end_table[stored_count[IDX_W-1:0]]   <= phys_end;
    end
  end

  // Run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
      header_count <= '0;
      highest_end  <= 32'h0;
      entry_seen   <= 1'b0;
      failed_flag  <= 1'b0;
    end else begin
      if ((state == S_START) && !failed_flag &&
          (header_count < HC_W'(MAX_HEADERS))) begin
        header_count <= header_count + HC_W'(1);
      end
      if (finish_load) begin
        if (last) begin
          stored_count <= '0;
          header_count <= '0;
          highest_end  <= 32'h0;
          entry_seen   <= 1'b0;
          failed_flag  <= 1'b0;
        end else begin
          stored_count <= count_new;
          highest_end  <= high_new;
          entry_seen   <= seen_new;
          failed_flag  <= failed_new;
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_load) begin
      out_status      <= status;
      out_fill_start  <= loaded ? phys + fsz : 32'h0;
      out_fill_length <= loaded ? msz - fsz : 32'h0;
      out_image_end   <= high_new;
      out_entry_found <= seen_new;
      out_run_done    <= last;
      out_final_entry <= (last && !failed_new && (count_new != SC_W'(0)) && seen_new)
                         ? entry_point : 32'h0;
    end
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.fill_start  = out_fill_start;
  assign res.fill_length = out_fill_length;
  assign res.image_end   = out_image_end;
  assign res.entry_found = out_entry_found;
  assign res.run_done    = out_run_done;
  assign res.final_entry = out_final_entry;

endmodule

`default_nettype wire
